@@ src/hrsp_pkg.sv @@
// Shared types, result kinds, character codes and tdata layout for the HTTP response parser.
package hrsp_pkg;

  // Result kind, carried on out_tuser
  typedef enum logic [2:0] {
    KIND_STATUS_BYTE = 3'd0,
    KIND_STATUS_DONE = 3'd1,
    KIND_HEADER_BYTE = 3'd2,
    KIND_HEADER_DONE = 3'd3,
    KIND_HEADERS_END = 3'd4,
    KIND_BODY        = 3'd5,
    KIND_ERROR       = 3'd6,
    KIND_IDLE        = 3'd7
  } kind_t;

  // Input command, carried on in_tuser
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Response phase
  typedef enum logic [3:0] {
    PH_STATUS = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  // Position within the status line
  typedef enum logic [2:0] {
    SP_PROTO = 3'b001,
    SP_CODE  = 3'b010,
    SP_MSG   = 3'b100
  } status_part_t;

  // Position within a header line
  typedef enum logic [3:0] {
    HP_KEY     = 4'b0001,
    HP_COLON   = 4'b0010,
    HP_VAL_PRE = 4'b0100,
    HP_VAL_DIG = 4'b1000
  } header_part_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam int unsigned PROTO_LEN = 4;
  localparam int unsigned KEY_LEN   = 14;

  // Output tdata layout, lowest bit up
  localparam int unsigned OUT_TDATA_W  = 96;
  localparam int unsigned OD_ECHO_LO   = 0;
  localparam int unsigned OD_STATUS_LO = 8;
  localparam int unsigned OD_ISLEN     = 24;
  localparam int unsigned OD_CLEN_LO   = 25;
  localparam int unsigned OD_OFF_LO    = 57;
  localparam int unsigned OD_DONE      = 89;
  localparam int unsigned OD_PAD_W     = 6;

  // "HTTP"
  function automatic logic [7:0] proto_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h54;
      2'd2:    c = 8'h54;
      2'd3:    c = 8'h50;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Content-Length"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/http_response_stream_parser.sv @@
// HTTP response parser: status line, headers with Content-Length, body byte counting.
//
// Feed a response one byte per beat on in_tdata with in_tuser low; a beat with
// in_tuser high starts a new response and clears every field of the parser,
// including the body length. Each input beat yields exactly one output beat
// whose out_tuser tells what the byte was (status byte, status line done,
// header byte, header line done, end of headers, body byte, error, idle).
// The status code is reported with the "status done" beat, the flag for a
// Content-Length header with the "header done" beat, and every body byte
// carries its offset and a done flag that rises on the byte that makes the
// count reach the length. A malformed line, or a line that would pass
// MAX_LINE bytes with its LF, moves the parser into an error phase that
// answers every byte with an error beat until the next new-response beat.
// Throughput is one byte per clock while out_tready is high: the per-byte
// state update (the times-ten-plus-digit accumulation of the length value and
// the 32-bit body offset compare) is combinational between the input register
// and the output register. Each byte passes through the input register and
// then the output register; a stalled output holds its beat while one more
// input beat waits in the input register.
module http_response_stream_parser #(
  parameter int unsigned MAX_LINE = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] echo_byte, [23:8] status_code, [24] is_length_header,
  // [56:25] content_length, [88:57] body_offset, [89] body_done, [95:90] zero
  output logic [hrsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]  out_tuser   // [2:0] kind
);

  localparam int unsigned LINE_W = $clog2(MAX_LINE);
  localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(MAX_LINE - 1);

  // Input register stage
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;

  // Parser state
  hrsp_pkg::phase_t       phase_r, phase_nxt;
  logic [LINE_W-1:0]      line_len_r, line_len_nxt;
  logic                   last_cr_r, last_cr_nxt;
  hrsp_pkg::status_part_t spart_r, spart_nxt;
  logic                   prefix_ok_r, prefix_ok_nxt;
  logic [15:0]            code_acc_r, code_acc_nxt;
  logic                   digits_open_r, digits_open_nxt;
  hrsp_pkg::header_part_t hpart_r, hpart_nxt;
  logic                   key_ok_r, key_ok_nxt;
  logic [31:0]            val_acc_r, val_acc_nxt;
  logic [31:0]            length_r, length_nxt;
  logic [31:0]            offset_r, offset_nxt;

  // Output register stage
  logic                            out_valid_r;
  hrsp_pkg::kind_t                 out_kind_r, out_kind_nxt;
  logic [hrsp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic s2_ready;
  logic advance;

  assign s2_ready  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // Per-byte work
  logic [7:0]  b;
  logic        b_digit;
  logic [3:0]  b_val;
  logic        eol;
  logic        line_clr;
  logic        key_ok_eff;
  logic        do_val_digit;
  logic [19:0] code_mul;
  logic [35:0] val_mul;
  logic        off_inc;
  logic [31:0] off_plus;
  logic [15:0] r_status;
  logic        r_islen;
  logic [31:0] r_off;
  logic        r_done;
  logic [7:0]  r_echo;

  always_comb begin
    b       = s1_byte_r;
    b_digit = (b >= hrsp_pkg::CH_0) && (b <= hrsp_pkg::CH_9);
    b_val   = 4'(b - hrsp_pkg::CH_0);
    eol     = (b == hrsp_pkg::CH_LF) && last_cr_r;

    code_mul = ({4'b0, code_acc_r} << 3) + ({4'b0, code_acc_r} << 1) + 20'(b_val);
    val_mul  = ({4'b0, val_acc_r} << 3) + ({4'b0, val_acc_r} << 1) + 36'(b_val);

    off_inc  = (offset_r != 32'hFFFF_FFFF);
    off_plus = offset_r + 32'd1;

    phase_nxt       = phase_r;
    line_len_nxt    = line_len_r;
    last_cr_nxt     = last_cr_r;
    spart_nxt       = spart_r;
    prefix_ok_nxt   = prefix_ok_r;
    code_acc_nxt    = code_acc_r;
    digits_open_nxt = digits_open_r;
    hpart_nxt       = hpart_r;
    key_ok_nxt      = key_ok_r;
    val_acc_nxt     = val_acc_r;
    length_nxt      = length_r;
    offset_nxt      = offset_r;
    line_clr        = 1'b0;
    key_ok_eff      = key_ok_r;
    do_val_digit    = 1'b0;

    out_kind_nxt = hrsp_pkg::KIND_ERROR;
    r_echo       = b;
    r_status     = 16'd0;
    r_islen      = 1'b0;
    r_off        = 32'd0;
    r_done       = 1'b0;

    if (s1_cmd_r == hrsp_pkg::CMD_RESET) begin
      // New response: clear everything, body length included
      phase_nxt    = hrsp_pkg::PH_STATUS;
      line_clr     = 1'b1;
      length_nxt   = 32'd0;
      offset_nxt   = 32'd0;
      out_kind_nxt = hrsp_pkg::KIND_IDLE;
      r_echo       = 8'd0;
    end else begin
      case (phase_r)
        hrsp_pkg::PH_BODY: begin
          // Count the byte; saturate the offset at all ones
          out_kind_nxt = hrsp_pkg::KIND_BODY;
          r_off        = offset_r;
          if (off_inc) begin
            offset_nxt = off_plus;
          end
          r_done = off_inc && (off_plus == length_r);
        end
        hrsp_pkg::PH_STATUS, hrsp_pkg::PH_HEADER: begin
          if (eol) begin
            if (phase_r == hrsp_pkg::PH_STATUS) begin
              if (prefix_ok_r && (spart_r == hrsp_pkg::SP_MSG)) begin
                out_kind_nxt = hrsp_pkg::KIND_STATUS_DONE;
                r_status     = code_acc_r;
                length_nxt   = 32'd0;
                phase_nxt    = hrsp_pkg::PH_HEADER;
                line_clr     = 1'b1;
              end else begin
                phase_nxt = hrsp_pkg::PH_ERROR;
              end
            end else if (line_len_r == LINE_W'(1)) begin
              // Empty line: headers end, body starts
              out_kind_nxt = hrsp_pkg::KIND_HEADERS_END;
              offset_nxt   = 32'd0;
              phase_nxt    = hrsp_pkg::PH_BODY;
              line_clr     = 1'b1;
            end else if ((hpart_r == hrsp_pkg::HP_VAL_PRE) ||
                         (hpart_r == hrsp_pkg::HP_VAL_DIG)) begin
              out_kind_nxt = hrsp_pkg::KIND_HEADER_DONE;
              r_islen      = key_ok_r;
              if (key_ok_r) begin
                length_nxt = val_acc_r;
              end
              line_clr = 1'b1;
            end else begin
              phase_nxt = hrsp_pkg::PH_ERROR;
            end
          end else if (line_len_r >= LINE_LIMIT) begin
            // Line would overflow the MAX_LINE length limit
            phase_nxt = hrsp_pkg::PH_ERROR;
          end else begin
            if (phase_r == hrsp_pkg::PH_STATUS) begin
              out_kind_nxt = hrsp_pkg::KIND_STATUS_BYTE;
              if ((line_len_r < LINE_W'(hrsp_pkg::PROTO_LEN)) &&
                  (b != hrsp_pkg::proto_char(line_len_r[1:0]))) begin
                prefix_ok_nxt = 1'b0;
              end
              case (spart_r)
                hrsp_pkg::SP_PROTO: begin
                  if (b == hrsp_pkg::CH_SP) begin
                    spart_nxt = hrsp_pkg::SP_CODE;
                  end
                end
                hrsp_pkg::SP_CODE: begin
                  if (b == hrsp_pkg::CH_SP) begin
                    spart_nxt = hrsp_pkg::SP_MSG;
                  end else if (digits_open_r && b_digit) begin
                    code_acc_nxt = (code_mul[19:16] != 4'd0) ? 16'hFFFF : code_mul[15:0];
                  end else begin
                    digits_open_nxt = 1'b0;
                  end
                end
                default: begin
                end
              endcase
            end else begin
              out_kind_nxt = hrsp_pkg::KIND_HEADER_BYTE;
              case (hpart_r)
                hrsp_pkg::HP_KEY, hrsp_pkg::HP_COLON: begin
                  if ((hpart_r == hrsp_pkg::HP_COLON) && (b == hrsp_pkg::CH_SP)) begin
                    hpart_nxt = hrsp_pkg::HP_VAL_PRE;
                  end else begin
                    // A colon not followed by a space spoils the key and keeps scanning
                    if (hpart_r == hrsp_pkg::HP_COLON) begin
                      key_ok_eff = 1'b0;
                    end
                    hpart_nxt = hrsp_pkg::HP_KEY;
                    if (b == hrsp_pkg::CH_COLON) begin
                      key_ok_eff = key_ok_eff &&
                                   (line_len_r == LINE_W'(hrsp_pkg::KEY_LEN));
                      hpart_nxt  = hrsp_pkg::HP_COLON;
                    end else if ((line_len_r >= LINE_W'(hrsp_pkg::KEY_LEN)) ||
                                 (b != hrsp_pkg::key_char(line_len_r[3:0]))) begin
                      key_ok_eff = 1'b0;
                    end
                    key_ok_nxt = key_ok_eff;
                  end
                end
                hrsp_pkg::HP_VAL_PRE: begin
                  // Skip leading blanks
                  if ((b != hrsp_pkg::CH_SP) && (b != hrsp_pkg::CH_TAB)) begin
                    if (b_digit) begin
                      do_val_digit = 1'b1;
                    end else begin
                      digits_open_nxt = 1'b0;
                    end
                    hpart_nxt = hrsp_pkg::HP_VAL_DIG;
                  end
                end
                hrsp_pkg::HP_VAL_DIG: begin
                  if (digits_open_r && b_digit) begin
                    do_val_digit = 1'b1;
                  end else begin
                    digits_open_nxt = 1'b0;
                  end
                end
                default: begin
                end
              endcase
              if (do_val_digit) begin
                val_acc_nxt = (val_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : val_mul[31:0];
              end
            end
            line_len_nxt = line_len_r + LINE_W'(1);
            last_cr_nxt  = (b == hrsp_pkg::CH_CR);
          end
        end
        default: begin
          // Error phase: hold
        end
      endcase
    end

    if (line_clr) begin
      line_len_nxt    = '0;
      last_cr_nxt     = 1'b0;
      spart_nxt       = hrsp_pkg::SP_PROTO;
      prefix_ok_nxt   = 1'b1;
      code_acc_nxt    = 16'd0;
      digits_open_nxt = 1'b1;
      hpart_nxt       = hrsp_pkg::HP_KEY;
      key_ok_nxt      = 1'b1;
      val_acc_nxt     = 32'd0;
    end

    out_data_nxt = {{hrsp_pkg::OD_PAD_W{1'b0}}, r_done, r_off, length_nxt,
                    r_islen, r_status, r_echo};
  end

  // Input register: take a beat whenever the stage is free or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
  end

  // Parser state: advance once per byte moved into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hrsp_pkg::PH_STATUS;
      line_len_r    <= '0;
      last_cr_r     <= 1'b0;
      spart_r       <= hrsp_pkg::SP_PROTO;
      prefix_ok_r   <= 1'b1;
      code_acc_r    <= 16'd0;
      digits_open_r <= 1'b1;
      hpart_r       <= hrsp_pkg::HP_KEY;
      key_ok_r      <= 1'b1;
      val_acc_r     <= 32'd0;
      length_r      <= 32'd0;
      offset_r      <= 32'd0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      line_len_r    <= line_len_nxt;
      last_cr_r     <= last_cr_nxt;
      spart_r       <= spart_nxt;
      prefix_ok_r   <= prefix_ok_nxt;
      code_acc_r    <= code_acc_nxt;
      digits_open_r <= digits_open_nxt;
      hpart_r       <= hpart_nxt;
      key_ok_r      <= key_ok_nxt;
      val_acc_r     <= val_acc_nxt;
      length_r      <= length_nxt;
      offset_r      <= offset_nxt;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule

@@ src/hrsp_chk.sv @@
// Port-level checker for the HTTP response parser, bound to the top level.
module hrsp_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hrsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                       out_tuser
);

  // Stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // New-response beat clears every payload field
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == hrsp_pkg::KIND_IDLE) |-> (out_tdata == '0))
    else $error("idle beat with nonzero payload");

  // Body done only on body beats
  a_done_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[hrsp_pkg::OD_DONE] |-> (out_tuser == hrsp_pkg::KIND_BODY))
    else $error("body_done outside body beat");

  // Status code only on the status-done beat
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[hrsp_pkg::OD_STATUS_LO +: 16] != 16'd0) |->
      (out_tuser == hrsp_pkg::KIND_STATUS_DONE))
    else $error("status_code outside status-done beat");

  // Length-header flag only on a header-done beat
  a_islen_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[hrsp_pkg::OD_ISLEN] |->
      (out_tuser == hrsp_pkg::KIND_HEADER_DONE))
    else $error("is_length_header outside header-done beat");

endmodule

bind http_response_stream_parser hrsp_chk u_hrsp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
